/* design/rlc_pkg.sv */
package rlc_pkg;

   // payload widths
   localparam int unsigned IndexWidth = 6;
   localparam int unsigned ByteWidth  = 6;
   localparam int unsigned HueWidth   = 8;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;

   // register map
   typedef enum logic {
      REG_HUE_STEP    = 1'b0,
      REG_HUE_SPACING = 1'b1
   } reg_index_type;

   localparam logic [HueWidth-1:0] HueStepReset    = 8'd3;
   localparam logic [HueWidth-1:0] HueSpacingReset = 8'd32;

   // color wheel segment boundaries
   localparam logic [HueWidth-1:0] SegMidStart  = 8'd85;
   localparam logic [HueWidth-1:0] SegRiseStart = 8'd170;
   localparam logic [HueWidth-1:0] FullScale    = 8'd255;

   typedef enum logic [1:0] {
      SEG_FALL = 2'd0,
      SEG_MID  = 2'd1,
      SEG_RISE = 2'd2
   } seg_type;

   // floor(x / 5) for 8-bit x as (x * 205) >> 10
   function automatic logic [ByteWidth-1:0] div5(input logic [HueWidth-1:0] x);
      logic [17:0] prod;
      prod = {10'd0, x} * 18'd205;
      return prod[10 +: ByteWidth];
   endfunction

endpackage

/* design/rlc_req_if.sv */
interface rlc_req_if;
   logic valid;
   logic ready;
   logic frame_request;

   modport source (output valid, output frame_request, input ready);
   modport sink   (input valid, input frame_request, output ready);
endinterface

/* design/rlc_rsp_if.sv */
interface rlc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [rlc_pkg::IndexWidth-1:0]    led_index;
   logic [rlc_pkg::ByteWidth-1:0]     first_byte;
   logic [rlc_pkg::ByteWidth-1:0]     second_byte;
   logic [rlc_pkg::ByteWidth-1:0]     third_byte;
   logic                              last_led;

   modport source (
      output valid, output led_index, output first_byte, output second_byte,
      output third_byte, output last_led, input ready
   );
   modport sink (
      input valid, input led_index, input first_byte, input second_byte,
      input third_byte, input last_led, output ready
   );
endinterface

/* design/rainbow_led_chain_color_generator.sv */
// channel      | direction | transaction
// -------------+-----------+-----------------------------------------------
// req_channel  | in        | frame_request, one per frame
// rsp_channel  | out       | led_index, three color bytes, last_led per led
// csr_*        | in        | apb write/read of hue_step and hue_spacing
//
// a frame request with frame_request set yields LED_COUNT transactions, one per cycle while rsp does not stall;
// the active flag is set when the request is taken, then led zero enters the output register;
// the led counter ends each frame; a request with frame_request clear is taken and produces nothing
// the next request is taken in the cycle the frame's last led enters the output register
// rsp stalls hold the output register and the led counter in place
// reset (synchronous, active high) clears the frame state and restores register defaults
module rainbow_led_chain_color_generator #(
   parameter int unsigned LED_COUNT = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   rlc_req_if.sink                             req_channel,
   rlc_rsp_if.source                           rsp_channel,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rlc_pkg::CsrAddrWidth-1:0]    csr_paddr,
   input  logic [rlc_pkg::CsrDataWidth-1:0]    csr_pwdata,
   output logic [rlc_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                csr_pready
);

   localparam logic [rlc_pkg::IndexWidth-1:0] LastIndex =
      rlc_pkg::IndexWidth'(LED_COUNT - 1);

   // configuration registers
   logic [rlc_pkg::HueWidth-1:0] hue_step_ff, hue_spacing_ff;
   logic                         csr_write;
   rlc_pkg::reg_index_type       csr_index;

   // frame generator state
   logic                           active_ff, active_in;
   logic [rlc_pkg::HueWidth-1:0]   offset_ff, offset_in;
   logic [rlc_pkg::HueWidth-1:0]   hue_ff, hue_in;
   logic [rlc_pkg::IndexWidth-1:0] index_ff, index_in;

   // output register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [rlc_pkg::IndexWidth-1:0] led_index_ff;
   logic [rlc_pkg::ByteWidth-1:0]  first_byte_ff, second_byte_ff, third_byte_ff;
   logic                           last_led_ff;

   logic advance;
   logic at_last;
   logic req_take;
   logic frame_start;

   // wheel datapath
   logic [rlc_pkg::HueWidth-1:0] wheel_p, wheel_q, rise_val, fall_val;
   rlc_pkg::seg_type             seg;
   logic [rlc_pkg::ByteWidth-1:0] rise_div, fall_div;
   logic [rlc_pkg::ByteWidth-1:0] first_in, second_in, third_in;

   // ---------------- csr port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = rlc_pkg::reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_step_ff    <= rlc_pkg::HueStepReset;
         hue_spacing_ff <= rlc_pkg::HueSpacingReset;
      end else if (csr_write) begin
         case (csr_index)
            rlc_pkg::REG_HUE_STEP:    hue_step_ff    <= csr_pwdata[rlc_pkg::HueWidth-1:0];
            rlc_pkg::REG_HUE_SPACING: hue_spacing_ff <= csr_pwdata[rlc_pkg::HueWidth-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         rlc_pkg::REG_HUE_STEP:
            csr_prdata = {{(rlc_pkg::CsrDataWidth-rlc_pkg::HueWidth){1'b0}}, hue_step_ff};
         rlc_pkg::REG_HUE_SPACING:
            csr_prdata = {{(rlc_pkg::CsrDataWidth-rlc_pkg::HueWidth){1'b0}}, hue_spacing_ff};
         default: csr_prdata = '0;
      endcase
   end

   // ---------------- handshake ----------------
   // the generator moves one led into the output register when that register frees up
   assign advance     = active_ff && (!rsp_valid_ff || rsp_channel.ready);
   assign at_last     = (index_ff == LastIndex);
   assign req_channel.ready = !active_ff || (advance && at_last);
   assign req_take    = req_channel.valid && req_channel.ready;
   assign frame_start = req_take && req_channel.frame_request;

   // ---------------- frame generator ----------------
   always_comb begin
      active_in = active_ff;
      offset_in = offset_ff;
      hue_in    = hue_ff;
      index_in  = index_ff;
      if (advance) begin
         // running hue replaces offset + index * spacing
         hue_in   = hue_ff + hue_spacing_ff;
         index_in = index_ff + 1'b1;
         if (at_last) begin
            active_in = 1'b0;
         end
      end
      if (frame_start) begin
         // the frame uses the current offset; the next frame sees it stepped
         active_in = 1'b1;
         hue_in    = offset_ff;
         index_in  = '0;
         offset_in = offset_ff + hue_step_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         offset_ff <= '0;
      end else begin
         active_ff <= active_in;
         offset_ff <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      hue_ff   <= hue_in;
      index_ff <= index_in;
   end

   // ---------------- color wheel ----------------
   // p = 255 - hue; each segment uses a rising ramp 3q and its complement 255 - 3q
   always_comb begin
      wheel_p = rlc_pkg::FullScale - hue_ff;
      if (wheel_p < rlc_pkg::SegMidStart) begin
         seg     = rlc_pkg::SEG_FALL;
         wheel_q = wheel_p;
      end else if (wheel_p < rlc_pkg::SegRiseStart) begin
         seg     = rlc_pkg::SEG_MID;
         wheel_q = wheel_p - rlc_pkg::SegMidStart;
      end else begin
         seg     = rlc_pkg::SEG_RISE;
         wheel_q = wheel_p - rlc_pkg::SegRiseStart;
      end
      // q never exceeds 85, so 3q fits in eight bits
      rise_val = (wheel_q << 1) + wheel_q;
      fall_val = rlc_pkg::FullScale - rise_val;
      rise_div = rlc_pkg::div5(rise_val);
      fall_div = rlc_pkg::div5(fall_val);
      case (seg)
         rlc_pkg::SEG_FALL: begin
            first_in  = fall_div;
            second_in = '0;
            third_in  = rise_div;
         end
         rlc_pkg::SEG_MID: begin
            first_in  = '0;
            second_in = rise_div;
            third_in  = fall_div;
         end
         rlc_pkg::SEG_RISE: begin
            first_in  = rise_div;
            second_in = fall_div;
            third_in  = '0;
         end
         default: begin
            first_in  = '0;
            second_in = '0;
            third_in  = '0;
         end
      endcase
   end

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_channel.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         led_index_ff   <= index_ff;
         first_byte_ff  <= first_in;
         second_byte_ff <= second_in;
         third_byte_ff  <= third_in;
         last_led_ff    <= at_last;
      end
   end

   assign rsp_channel.valid       = rsp_valid_ff;
   assign rsp_channel.led_index   = led_index_ff;
   assign rsp_channel.first_byte  = first_byte_ff;
   assign rsp_channel.second_byte = second_byte_ff;
   assign rsp_channel.third_byte  = third_byte_ff;
   assign rsp_channel.last_led    = last_led_ff;

`ifndef NO_ASSERTIONS
   // a new request is taken mid-frame only as the last led moves out
   assert property (@(posedge clock) disable iff (reset)
      (active_ff && req_channel.ready) |-> (advance && at_last))
      else $error("request taken in the middle of a frame");

   // a frame start always leaves the generator busy with led zero
   assert property (@(posedge clock) disable iff (reset)
      frame_start |=> (active_ff && index_ff == '0))
      else $error("frame start did not arm the generator");

   // the last led flag marks exactly the final index of the chain
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (last_led_ff == (led_index_ff == LastIndex)))
      else $error("last led flag out of step with the led index");

   // every wheel color has at least one dark component
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (first_byte_ff == '0 || second_byte_ff == '0 || third_byte_ff == '0))
      else $error("wheel output has no dark component");
`endif

endmodule
